// ===== rtl/core/ecm_pkg.sv =====
package ecm_pkg;

    // Function codes carried in the request.
    localparam logic [1:0] FUNC_MARK  = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Subband codes that change the significance rules.
    localparam logic [1:0] BAND_SWAP = 2'd1;
    localparam logic [1:0] BAND_DIAG = 2'd3;

    localparam int CELL_W = 13;

    // Bit positions inside one flag cell.
    localparam int NB_N  = 0;
    localparam int NB_E  = 1;
    localparam int NB_W  = 2;
    localparam int NB_S  = 3;
    localparam int NB_NE = 4;
    localparam int NB_NW = 5;
    localparam int NB_SE = 6;
    localparam int NB_SW = 7;
    localparam int NEG_N = 8;
    localparam int NEG_S = 9;
    localparam int NEG_W = 10;
    localparam int NEG_E = 11;
    localparam int SELF  = 12;

    // Number of cells touched by one mark.
    localparam logic [3:0] MARK_STEPS = 4'd9;

    localparam logic [3:0] SIGN_LABEL [0:2][0:2] = '{
        '{4'd13, 4'd12, 4'd11},
        '{4'd10, 4'd9,  4'd10},
        '{4'd11, 4'd12, 4'd13}
    };
    localparam logic SIGN_FLIP [0:2][0:2] = '{
        '{1'b1, 1'b1, 1'b1},
        '{1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0}
    };

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] col;
        logic [5:0] row;
        logic       negative;
    } ecm_req_t;

    typedef struct packed {
        logic [3:0] sig_context;
        logic [3:0] sign_context;
        logic       sign_xor;
        logic       self_significant;
    } ecm_rsp_t;

    // Flags ORed into the cell visited at a given step of a mark. The step
    // order is center, east, west, south, north, south-east, south-west,
    // north-east, north-west of the marked coefficient.
    function automatic logic [CELL_W-1:0] mark_bits(logic [3:0] step, logic neg);
        logic [CELL_W-1:0] bits;
        bits = '0;
        case (step)
            4'd0: bits[SELF] = 1'b1;
            4'd1: begin
                bits[NB_W]  = 1'b1;
                bits[NEG_W] = neg;
            end
            4'd2: begin
                bits[NB_E]  = 1'b1;
                bits[NEG_E] = neg;
            end
            4'd3: begin
                bits[NB_N]  = 1'b1;
                bits[NEG_N] = neg;
            end
            4'd4: begin
                bits[NB_S]  = 1'b1;
                bits[NEG_S] = neg;
            end
            4'd5: bits[NB_NW] = 1'b1;
            4'd6: bits[NB_NE] = 1'b1;
            4'd7: bits[NB_SW] = 1'b1;
            4'd8: bits[NB_SE] = 1'b1;
            default: bits = '0;
        endcase
        return bits;
    endfunction

    function automatic logic [3:0] sig_ctx(logic [CELL_W-1:0] flags, logic [1:0] band);
        logic [1:0] h;
        logic [1:0] v;
        logic [1:0] t;
        logic [2:0] d;
        logic [2:0] hv;
        logic [3:0] ctx;
        h  = {1'b0, flags[NB_E]} + {1'b0, flags[NB_W]};
        v  = {1'b0, flags[NB_N]} + {1'b0, flags[NB_S]};
        d  = {2'b00, flags[NB_NE]} + {2'b00, flags[NB_NW]} +
             {2'b00, flags[NB_SE]} + {2'b00, flags[NB_SW]};
        hv = {1'b0, h} + {1'b0, v};
        ctx = 4'd0;
        if (band != BAND_DIAG) begin
            if (band == BAND_SWAP) begin
                t = h;
                h = v;
                v = t;
            end
            if (h == 2'd2)      ctx = 4'd8;
            else if (h == 2'd1) ctx = (v != 2'd0) ? 4'd7 : ((d != 3'd0) ? 4'd6 : 4'd5);
            else if (v == 2'd2) ctx = 4'd4;
            else if (v == 2'd1) ctx = 4'd3;
            else if (d >= 3'd2) ctx = 4'd2;
            else if (d == 3'd1) ctx = 4'd1;
            else                ctx = 4'd0;
        end else begin
            if (d >= 3'd3)      ctx = 4'd8;
            else if (d == 3'd2) ctx = (hv != 3'd0) ? 4'd7 : 4'd6;
            else if (d == 3'd1) ctx = (hv >= 3'd2) ? 4'd5 : ((hv == 3'd1) ? 4'd4 : 4'd3);
            else if (hv >= 3'd2) ctx = 4'd2;
            else if (hv == 3'd1) ctx = 4'd1;
            else                 ctx = 4'd0;
        end
        return ctx;
    endfunction

    // Signed contribution of one direct neighbor: -1, 0 or +1.
    function automatic logic signed [2:0] side(logic sig, logic neg);
        return sig ? (neg ? -3'sd1 : 3'sd1) : 3'sd0;
    endfunction

    // Collapse a sum of two contributions onto table index 0, 1 or 2.
    function automatic logic [1:0] clamp_idx(logic signed [2:0] s);
        logic [1:0] idx;
        if (s > 3'sd0)      idx = 2'd2;
        else if (s < 3'sd0) idx = 2'd0;
        else                idx = 2'd1;
        return idx;
    endfunction

    // Returns the sign context label and the sign xor bit.
    function automatic logic [4:0] sign_ctx(logic [CELL_W-1:0] flags);
        logic [1:0] hi;
        logic [1:0] vi;
        hi = clamp_idx(side(flags[NB_E], flags[NEG_E]) + side(flags[NB_W], flags[NEG_W]));
        vi = clamp_idx(side(flags[NB_S], flags[NEG_S]) + side(flags[NB_N], flags[NEG_N]));
        return {SIGN_LABEL[hi][vi], SIGN_FLIP[hi][vi]};
    endfunction

endpackage

// ===== rtl/core/ebcot_context_modeler.sv =====
// A mark steps through its nine cells in ST_MARK, a query passes ST_QRD and ST_QEVAL,
// a clear sweeps every cell in ST_CLEAR, and any other request goes straight to ST_DONE.
// One request at a time; the next is taken the cycle after its result is loaded.
// The flag memory has one read and one write port; it does the nine
// read-modify-writes of a mark one cell per cycle.
// Reset (aresetn low, synchronous) starts a clearing pass of (W+2)*(H+2) cells, 4356 by default.
module ebcot_context_modeler #(
    parameter int BLOCK_WIDTH  = 64,
    parameter int BLOCK_HEIGHT = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ecm_pkg::ecm_req_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ecm_pkg::ecm_rsp_t m_data,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_wdata
);

    import ecm_pkg::*;

    // The flag map carries a one-cell border on every side, so that the
    // neighbors of an edge coefficient are real cells and need no masking.
    localparam int STRIDE = BLOCK_WIDTH + 2;
    localparam int CELLS  = STRIDE * (BLOCK_HEIGHT + 2);
    localparam int AW     = $clog2(CELLS);

    localparam logic [AW-1:0] ONE_A    = AW'(1);
    localparam logic [AW-1:0] STRIDE_A = AW'(STRIDE);
    localparam logic [AW-1:0] S_P1_A   = AW'(STRIDE + 1);
    localparam logic [AW-1:0] S_M1_A   = AW'(STRIDE - 1);
    localparam logic [AW-1:0] WIDTH_A  = AW'(BLOCK_WIDTH);
    localparam logic [AW-1:0] HEIGHT_A = AW'(BLOCK_HEIGHT);
    localparam logic [AW-1:0] LAST_A   = AW'(CELLS - 1);

    // ST_INIT is the clearing pass after reset, ST_CLEAR the one a clear
    // request starts. ST_DONE hands the finished result to the output register.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_MARK,
        ST_QRD,
        ST_QEVAL,
        ST_CLEAR,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     center_reg, center_next;
    logic              neg_reg, neg_next;
    logic [3:0]        step_reg, step_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic [AW-1:0]     wr_addr_reg, wr_addr_next;
    logic [CELL_W-1:0] wr_bits_reg, wr_bits_next;
    ecm_rsp_t          res_reg, res_next;
    logic [1:0]        band_reg, band_next;
    logic              m_valid_reg, m_valid_next;
    ecm_rsp_t          m_data_reg, m_data_next;

    logic [AW-1:0]     col_a;
    logic [AW-1:0]     row_a;
    logic              in_block;
    logic [AW-1:0]     cell_addr;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;
    logic [4:0]        sign_res;

    assign col_a    = AW'(s_data.col);
    assign row_a    = AW'(s_data.row);
    assign in_block = (col_a < WIDTH_A) && (row_a < HEIGHT_A);

    // Address of the cell visited at the current step. Step 0 is the
    // coefficient itself, which is also the address a query reads.
    always_comb begin
        case (step_reg)
            4'd0:    cell_addr = center_reg;
            4'd1:    cell_addr = center_reg + ONE_A;
            4'd2:    cell_addr = center_reg - ONE_A;
            4'd3:    cell_addr = center_reg + STRIDE_A;
            4'd4:    cell_addr = center_reg - STRIDE_A;
            4'd5:    cell_addr = center_reg + S_P1_A;
            4'd6:    cell_addr = center_reg + S_M1_A;
            4'd7:    cell_addr = center_reg - S_M1_A;
            4'd8:    cell_addr = center_reg - S_P1_A;
            default: cell_addr = center_reg;
        endcase
    end

    // A mark reads cell k while it writes back cell k-1 with the new flags
    // ORed in. The nine cells are distinct, so the read never sees a write
    // in flight, and all writes land before the next request is taken.
    always_comb begin
        if (state_reg == ST_MARK) begin
            ram_we    = (step_reg != 4'd0);
            ram_waddr = wr_addr_reg;
            ram_wdata = ram_rdata | wr_bits_reg;
        end else begin
            ram_we    = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
            ram_waddr = sweep_reg;
            ram_wdata = '0;
        end
    end

    ecm_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_flag_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(cell_addr),
        .rdata(ram_rdata)
    );

    assign sign_res = sign_ctx(ram_rdata);

    always_comb begin
        state_next   = state_reg;
        center_next  = center_reg;
        neg_next     = neg_reg;
        step_next    = step_reg;
        sweep_next   = sweep_reg;
        wr_addr_next = cell_addr;
        wr_bits_next = mark_bits(step_reg, neg_reg);
        res_next     = res_reg;
        band_next    = cfg_we ? cfg_wdata : band_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (state_reg)
            ST_INIT: begin
                sweep_next = sweep_reg + ONE_A;
                if (sweep_reg == LAST_A) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    center_next = (row_a + ONE_A) * STRIDE_A + col_a + ONE_A;
                    neg_next    = s_data.negative;
                    step_next   = 4'd0;
                    sweep_next  = '0;
                    // Anything but a query inside the block answers zero.
                    res_next    = '0;
                    if (s_data.func == FUNC_CLEAR) begin
                        state_next = ST_CLEAR;
                    end else if (s_data.func == FUNC_MARK && in_block) begin
                        state_next = ST_MARK;
                    end else if (s_data.func == FUNC_QUERY && in_block) begin
                        state_next = ST_QRD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MARK: begin
                step_next = step_reg + 4'd1;
                if (step_reg == MARK_STEPS) begin
                    state_next = ST_DONE;
                end
            end
            ST_QRD: begin
                state_next = ST_QEVAL;
            end
            ST_QEVAL: begin
                res_next.sig_context      = sig_ctx(ram_rdata, band_reg);
                res_next.sign_context     = sign_res[4:1];
                res_next.sign_xor         = sign_res[0];
                res_next.self_significant = ram_rdata[SELF];
                state_next = ST_DONE;
            end
            ST_CLEAR: begin
                sweep_next = sweep_reg + ONE_A;
                if (sweep_reg == LAST_A) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // The result waits here until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            sweep_reg   <= '0;
            step_reg    <= 4'd0;
            band_reg    <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            step_reg    <= step_next;
            band_reg    <= band_next;
            m_valid_reg <= m_valid_next;
            center_reg  <= center_next;
            neg_reg     <= neg_next;
            wr_addr_reg <= wr_addr_next;
            wr_bits_reg <= wr_bits_next;
            res_reg     <= res_next;
            m_data_reg  <= m_data_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/ecm_ram.sv =====
module ecm_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4356
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ecm_checker.sv =====
module ecm_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input ecm_pkg::ecm_rsp_t m_data
);

    import ecm_pkg::*;

    // A result is held until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    // Requests are served one at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in progress");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.sig_context <= 4'd8)
        else $error("significance context out of range");

    // A result is either a full query answer or all zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.sign_context >= 4'd9 && m_data.sign_context <= 4'd13) ||
                    (m_data == '0))
        else $error("malformed sign context");

endmodule

bind ebcot_context_modeler ecm_checker u_ecm_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
